// File: hw/rtl/gkl_pkg.sv
package gkl_pkg;

  // Field widths.
  localparam int unsigned DataW  = 32;
  localparam int unsigned DistW  = 48;
  localparam int unsigned DvdW   = 64;
  localparam int unsigned TermW  = 51;
  localparam int unsigned StepW  = 7;

  // Reset value of the variance floor: 10.0 in unsigned Q16.16.
  localparam logic [DataW-1:0] FloorReset = 32'd655360;

  // Largest distance, and the clamp on each mean term (2^49).
  localparam logic [DistW-1:0] DistMax  = {DistW{1'b1}};
  localparam logic [TermW-1:0] MeanCap  = TermW'(64'h2_0000_0000_0000);
  // 2.0 in Q.16.
  localparam logic [TermW-1:0] TwoQ16   = TermW'(64'd131072);

  // Quotient bits produced for each kind of division.
  localparam logic [StepW-1:0] RatioSteps = 7'd48;
  localparam logic [StepW-1:0] MeanSteps  = 7'd64;

  typedef struct packed {
    logic              start;
    logic [DvdW-1:0]   dividend;   // left-aligned on the quotient window
    logic [DataW-1:0]  divisor;
    logic [StepW-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DvdW-1:0]   quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/gkl_div.sv
// Restoring radix-2 divider: one quotient bit per cycle.
module gkl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gkl_pkg::div_req_t req_i,
  output gkl_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [gkl_pkg::StepW-1:0]    count_q, count_d;
  logic [gkl_pkg::DataW-1:0]    rem_q, rem_d;
  logic [gkl_pkg::DataW-1:0]    dvs_q, dvs_d;
  logic [gkl_pkg::DvdW-1:0]     dvd_q, dvd_d;
  logic [gkl_pkg::DataW:0]      trial;
  logic                         qbit;

  assign trial = {rem_q, dvd_q[gkl_pkg::DvdW-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    count_d = count_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    dvd_d   = dvd_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      count_d = req_i.steps;
      rem_d   = '0;
      dvs_d   = req_i.divisor;
      dvd_d   = req_i.dividend;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits in DataW bits.
      rem_d   = qbit ? gkl_pkg::DataW'(trial - {1'b0, dvs_q})
                     : trial[gkl_pkg::DataW-1:0];
      dvd_d   = {dvd_q[gkl_pkg::DvdW-2:0], qbit};
      count_d = count_q - 1'b1;
      if (count_q == gkl_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// File: hw/rtl/gaussian_kl_distance.sv
// Each dimension is accepted in the idle state, squared, then divided four times on the shared
// radix-2 divider (48 + 48 + 64 + 64 quotient bits, with a start and a wait state per division)
// and accumulated; if a variance is zero after flooring, it goes straight to accumulate.
// A dimension marked last then passes the emit state, which waits while the result register
// is still full. in_ready_o is low until a dimension is through, so they never overlap.
// Reset (rst_ni low, asynchronous) clears total, sticky flag and control; floor becomes 10.0.
module gaussian_kl_distance (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel: variance floor, unsigned Q16.16.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_variance_floor_i,

  // One dimension per input transaction.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] mean_a_i,
  input  logic [31:0] var_a_i,
  input  logic signed [31:0] mean_b_i,
  input  logic [31:0] var_b_i,
  input  logic        last_dim_i,

  // One result transaction after each dimension marked last.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] distance_o,
  output logic        saturated_o
);

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StStart  = 3'd2;
  localparam logic [2:0] StWait   = 3'd3;
  localparam logic [2:0] StAcc    = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;

  // The four divisions, issued in this order.
  localparam logic [1:0] OpRatioA = 2'd0;  // va * 2^16 / vb
  localparam logic [1:0] OpRatioB = 2'd1;  // vb * 2^16 / va
  localparam logic [1:0] OpMeanA  = 2'd2;  // d^2 / va
  localparam logic [1:0] OpMeanB  = 2'd3;  // d^2 / vb

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   op_q, op_d;
  logic [31:0]                  floor_q;
  logic [31:0]                  va_q, va_d, vb_q, vb_d;
  logic [31:0]                  ad_q, ad_d;
  logic [63:0]                  dsq_q, dsq_d;
  logic                         last_q, last_d;
  logic                         zero_q, zero_d;
  logic [gkl_pkg::TermW-1:0]    term_q, term_d;
  logic [gkl_pkg::DistW-1:0]    total_q, total_d;
  logic                         sticky_q, sticky_d;
  logic                         out_valid_q, out_valid_d;
  logic [gkl_pkg::DistW-1:0]    out_dist_q, out_dist_d;
  logic                         out_sat_q, out_sat_d;

  logic                         in_fire;
  logic [31:0]                  va_floor, vb_floor;
  logic signed [32:0]           diff;
  gkl_pkg::div_req_t            div_req;
  gkl_pkg::div_rsp_t            div_rsp;
  logic [gkl_pkg::TermW-1:0]    addend;
  logic [gkl_pkg::TermW-1:0]    term_net;
  logic [gkl_pkg::DistW+3:0]    total_sum;
  logic                         out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Variance floor register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= gkl_pkg::FloorReset;
    end else if (cfg_valid_i) begin
      floor_q <= cfg_variance_floor_i;
    end
  end

  // Floor both variances and form |mean_a - mean_b| as the item is taken.
  assign va_floor = (var_a_i < floor_q) ? floor_q : var_a_i;
  assign vb_floor = (var_b_i < floor_q) ? floor_q : var_b_i;
  assign diff     = {mean_a_i[31], mean_a_i} - {mean_b_i[31], mean_b_i};

  // The divider request for the current operation. Ratio dividends are
  // va * 2^16, 48 bits wide, so they are placed at the top of the 64-bit word.
  always_comb begin
    div_req.start = (state_q == StStart);
    case (op_q)
      OpRatioA: begin
        div_req.dividend = {va_q, 32'd0};
        div_req.divisor  = vb_q;
        div_req.steps    = gkl_pkg::RatioSteps;
      end
      OpRatioB: begin
        div_req.dividend = {vb_q, 32'd0};
        div_req.divisor  = va_q;
        div_req.steps    = gkl_pkg::RatioSteps;
      end
      OpMeanA: begin
        div_req.dividend = dsq_q;
        div_req.divisor  = va_q;
        div_req.steps    = gkl_pkg::MeanSteps;
      end
      default: begin
        div_req.dividend = dsq_q;
        div_req.divisor  = vb_q;
        div_req.steps    = gkl_pkg::MeanSteps;
      end
    endcase
  end

  gkl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Ratio quotients stay below 2^48; mean quotients are clamped at 2^49.
  always_comb begin
    if (op_q == OpRatioA || op_q == OpRatioB) begin
      addend = div_rsp.quotient[gkl_pkg::TermW-1:0];
    end else if (div_rsp.quotient > 64'(gkl_pkg::MeanCap)) begin
      addend = gkl_pkg::MeanCap;
    end else begin
      addend = div_rsp.quotient[gkl_pkg::TermW-1:0];
    end
  end

  // Subtract 2.0, flooring at zero, then add into the total with saturation.
  assign term_net  = (term_q >= gkl_pkg::TwoQ16) ? (term_q - gkl_pkg::TwoQ16) : '0;
  assign total_sum = {4'd0, total_q} + {1'b0, term_net};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    va_d        = va_q;
    vb_d        = vb_q;
    ad_d        = ad_q;
    dsq_d       = dsq_q;
    last_d      = last_q;
    zero_d      = zero_q;
    term_d      = term_q;
    total_d     = total_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dist_d  = out_dist_q;
    out_sat_d   = out_sat_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          va_d   = va_floor;
          vb_d   = vb_floor;
          ad_d   = diff[32] ? 32'(-diff) : diff[31:0];
          last_d = last_dim_i;
          zero_d = (va_floor == '0) || (vb_floor == '0);
          term_d = '0;
          op_d   = OpRatioA;
          // A zero variance skips the arithmetic altogether.
          state_d = ((va_floor == '0) || (vb_floor == '0)) ? StAcc : StSquare;
        end
      end
      StSquare: begin
        dsq_d   = ad_q * ad_q;
        state_d = StStart;
      end
      StStart: begin
        state_d = StWait;
      end
      StWait: begin
        if (div_rsp.done) begin
          term_d = term_q + addend;
          if (op_q == OpMeanB) begin
            state_d = StAcc;
          end else begin
            op_d    = op_q + 2'd1;
            state_d = StStart;
          end
        end
      end
      StAcc: begin
        if (zero_q || (total_sum[gkl_pkg::DistW+3:gkl_pkg::DistW] != '0)) begin
          total_d  = gkl_pkg::DistMax;
          sticky_d = 1'b1;
        end else begin
          total_d = total_sum[gkl_pkg::DistW-1:0];
        end
        state_d = last_q ? StEmit : StIdle;
      end
      StEmit: begin
        // Wait for the result register to drain, then hand over and start afresh.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = total_q;
          out_sat_d   = sticky_q;
          total_d     = '0;
          sticky_d    = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpRatioA;
      total_q     <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      total_q     <= total_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      zero_q      <= zero_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    va_q       <= va_d;
    vb_q       <= vb_d;
    ad_q       <= ad_d;
    dsq_q      <= dsq_d;
    term_q     <= term_d;
    out_dist_q <= out_dist_d;
    out_sat_q  <= out_sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign saturated_o = out_sat_q;

endmodule
